FILE: hw/rtl/serial_to_i2c_command_translator_assert.svh
// assertion macros for the serial to i2c command translator rtl, used by its datapath
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef SERIAL_TO_I2C_COMMAND_TRANSLATOR_ASSERT_SVH
`define SERIAL_TO_I2C_COMMAND_TRANSLATOR_ASSERT_SVH

// condition must hold at every edge out of reset
`define S2ICT_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("s2ict assertion failed");

// antecedent implies consequent in the same cycle
`define S2ICT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s2ict implication failed");

// antecedent implies consequent in the next cycle
`define S2ICT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s2ict next-cycle check failed");

`endif

FILE: hw/rtl/s2ict_pkg.sv
// shared types and constants of the serial to i2c command translator
// used by the controller, the datapath and the top level
package s2ict_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned RECV_W  = 6;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned USER_W  = OP_W + 1;

  localparam logic [BYTE_W-1:0] MAX_RECV   = 8'd32;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_START_WRITE = 3'd0,
    OP_WRITE       = 3'd1,
    OP_START_READ  = 3'd2,
    OP_READ        = 3'd3,
    OP_STOP        = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SCOUNT,
    ST_RCOUNT,
    ST_DATA,
    ST_EMIT_SW,
    ST_EMIT_WR,
    ST_EMIT_SR,
    ST_EMIT_RD,
    ST_EMIT_STOP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_addr;
    logic load_sends;
    logic load_reads;
    logic load_data;
    logic dec_reads;
    logic clear;
    logic emit;
    op_t  op;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rx_start;
    logic sends_nz;
    logic reads_nz;
    logic reads_one;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/s2ict_dp.sv
// datapath: frame header registers, latched send byte and output register
// depends on s2ict_pkg and the assertion macro header
`include "serial_to_i2c_command_translator_assert.svh"

module s2ict_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [s2ict_pkg::BYTE_W-1:0]  rx_byte,
  input  s2ict_pkg::cmd_t               cmd,
  output s2ict_pkg::sts_t               sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [s2ict_pkg::BYTE_W-1:0]  out_byte,
  output logic [s2ict_pkg::OP_W-1:0]    out_op,
  output logic                          out_ack,
  output logic                          out_last
);
  import s2ict_pkg::*;

  logic [ADDR_W-1:0] target_address;
  logic [BYTE_W-1:0] sends_left;
  logic [RECV_W-1:0] reads_to_do;
  logic [BYTE_W-1:0] data_byte;
  logic [RECV_W-1:0] reads_sat;
  logic [BYTE_W-1:0] byte_next;
  logic              ack_next;

  assign reads_sat = (rx_byte > MAX_RECV) ? MAX_RECV[RECV_W-1:0] : rx_byte[RECV_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
      sends_left     <= '0;
      reads_to_do    <= '0;
    end else begin
      if (cmd.load_addr)  target_address <= rx_byte[ADDR_W-1:0];
      if (cmd.load_sends) sends_left <= rx_byte;
      if (cmd.load_reads) reads_to_do <= reads_sat;
      if (cmd.load_data)  sends_left <= sends_left - 8'd1;
      if (cmd.dec_reads)  reads_to_do <= reads_to_do - 6'd1;
      if (cmd.clear) begin
        sends_left  <= '0;
        reads_to_do <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_data) data_byte <= rx_byte;
  end

  always_comb begin
    byte_next = '0;
    ack_next  = 1'b0;
    case (cmd.op)
      OP_START_WRITE: byte_next = {target_address, 1'b0};
      OP_START_READ:  byte_next = {target_address, 1'b1};
      OP_WRITE:       byte_next = data_byte;
      OP_READ:        ack_next  = !sts.reads_one;
      default:        byte_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= byte_next;
      out_op   <= cmd.op;
      out_ack  <= ack_next;
      out_last <= cmd.last;
    end
  end

  assign sts.rx_start  = (rx_byte == START_BYTE);
  assign sts.sends_nz  = (sends_left != '0);
  assign sts.reads_nz  = (reads_to_do != '0);
  assign sts.reads_one = (reads_to_do == 6'd1);
  assign sts.out_free  = !out_valid || out_ready;

  // a pending op must never be overwritten
  `S2ICT_ASSERT_IMP(a_no_overwrite, cmd.emit, !out_valid || out_ready)
  // a send byte only arrives while sends remain
  `S2ICT_ASSERT_IMP(a_send_in_range, cmd.load_data, sends_left != '0)
  // reads are only issued while the count is nonzero
  `S2ICT_ASSERT_IMP(a_read_in_range, cmd.emit && cmd.op == OP_READ, reads_to_do != '0)
  // a stop always closes the run and clears the counters
  `S2ICT_ASSERT_NXT(a_stop_clears, cmd.emit && cmd.op == OP_STOP,
                    out_last && sends_left == '0 && reads_to_do == '0)
endmodule

FILE: hw/rtl/s2ict_ctrl.sv
// controller: frame parsing and bus op sequencing state machine
// depends on s2ict_pkg; drives the datapath through cmd_t only
module s2ict_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output s2ict_pkg::cmd_t  cmd,
  input  s2ict_pkg::sts_t  sts
);
  import s2ict_pkg::*;

  state_t state, state_next;
  logic   in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire && sts.rx_start) state_next = ST_ADDR;
      ST_ADDR:   if (in_fire) state_next = ST_SCOUNT;
      ST_SCOUNT: if (in_fire) state_next = ST_RCOUNT;
      ST_RCOUNT: if (in_fire) state_next = ST_EMIT_SW;
      ST_DATA:   if (in_fire) state_next = ST_EMIT_WR;
      ST_EMIT_SW, ST_EMIT_WR: begin
        if (sts.out_free) begin
          if (sts.sends_nz) state_next = ST_DATA;
          else if (sts.reads_nz) state_next = ST_EMIT_SR;
          else state_next = ST_EMIT_STOP;
        end
      end
      ST_EMIT_SR: if (sts.out_free) state_next = ST_EMIT_RD;
      ST_EMIT_RD: begin
        if (sts.out_free && sts.reads_one) state_next = ST_EMIT_STOP;
      end
      ST_EMIT_STOP: if (sts.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ready is high in every parsing state, so valid alone marks the accept there
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.op         = OP_STOP;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_ADDR: begin
        in_ready      = 1'b1;
        cmd.load_addr = in_valid;
      end
      ST_SCOUNT: begin
        in_ready       = 1'b1;
        cmd.load_sends = in_valid;
      end
      ST_RCOUNT: begin
        in_ready       = 1'b1;
        cmd.load_reads = in_valid;
      end
      ST_DATA: begin
        in_ready      = 1'b1;
        cmd.load_data = in_valid;
      end
      ST_EMIT_SW: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_START_WRITE;
        cmd.last = sts.sends_nz;
      end
      ST_EMIT_WR: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_WRITE;
        cmd.last = sts.sends_nz;
      end
      ST_EMIT_SR: begin
        cmd.emit = sts.out_free;
        cmd.op   = OP_START_READ;
      end
      ST_EMIT_RD: begin
        cmd.emit      = sts.out_free;
        cmd.op        = OP_READ;
        cmd.dec_reads = sts.out_free;
      end
      ST_EMIT_STOP: begin
        cmd.emit  = sts.out_free;
        cmd.op    = OP_STOP;
        cmd.last  = 1'b1;
        cmd.clear = sts.out_free;
      end
      default: in_ready = 1'b0;
    endcase
  end
endmodule

FILE: hw/rtl/serial_to_i2c_command_translator.sv
// top level of the serial to i2c command translator
// depends on s2ict_pkg, s2ict_ctrl and s2ict_dp
//
// usage:
//   the slave channel takes one serial byte per item. a frame is a start
//   byte 0x00, the 7-bit target address, a send count, a receive count and
//   the send bytes; bytes outside a frame are dropped without a result.
//   the master channel gives one i2c bus op per item, one per cycle at most:
//   tdata is the bus byte, tuser the op code and read ack, tlast marks the
//   final op caused by one input byte.
//   the first op of a byte is registered: accepting the byte moves the
//   sequencer into an emit state, which loads the output register. the next
//   byte is taken once all ops of the last one are in the output register
//   (receive counts are capped at 32); header bytes that cause nothing do
//   not hold it off. one op per cycle enters the output register when free.
//   a stalled master side holds the op in the output register and pauses
//   the sequencer; the next byte may be accepted while the last op of a run
//   still waits.
//   reset: synchronous, active high; returns to waiting for a start byte
//   and clears the address and counts.
module serial_to_i2c_command_translator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [s2ict_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [s2ict_pkg::BYTE_W-1:0]  m_axis_tdata,  // [7:0] bus_byte
  output logic [s2ict_pkg::USER_W-1:0]  m_axis_tuser,  // [2:0] bus_op, [3] read_ack
  output logic                          m_axis_tlast   // last_of_run
);
  import s2ict_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [OP_W-1:0] out_op;
  logic            out_ack;

  s2ict_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  s2ict_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_op    (out_op),
    .out_ack   (out_ack),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_ack, out_op};
endmodule

FILE: bench/tb_serial_to_i2c_command_translator.sv
// testbench for serial_to_i2c_command_translator: directed and random frames and noise
// bytes are streamed in, every bus op is checked against a frame parser in the bench
// depends on s2ict_pkg and the top level rtl
`timescale 1ns / 100ps

module tb_serial_to_i2c_command_translator;
  import s2ict_pkg::*;

  typedef enum logic [2:0] {
    FR_WAIT_START,
    FR_ADDR,
    FR_SENDS,
    FR_RECVS,
    FR_DATA
  } frame_phase_t;

  typedef struct {
    op_t        op;
    logic [7:0] bus_byte;
    logic       read_ack;
    logic       last;
  } bus_op_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata  = '0;  // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]   m_axis_tdata;        // [7:0] bus_byte
  logic [USER_W-1:0]   m_axis_tuser;        // [2:0] bus_op, [3] read_ack
  logic                m_axis_tlast;

  serial_to_i2c_command_translator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [7:0]   serial_bytes[$];
  bus_op_t      expected_ops[$];
  bus_op_t      op_run[$];

  frame_phase_t fr_phase = FR_WAIT_START;
  logic [6:0]   fr_addr  = '0;
  logic [7:0]   fr_sends = '0;
  logic [5:0]   fr_reads = '0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  send_hold      = 1'b0;
  bit  long_hold_go   = 1'b0;
  bit  recv_holding   = 1'b0;
  bit  s_fire         = 1'b0;

  int  errors        = 0;
  int  bytes_taken   = 0;
  int  ops_checked   = 0;
  int  frames_queued = 0;
  int  random_items  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void push_op(input op_t op, input logic [7:0] b, input logic ack);
    bus_op_t e;
    e.op       = op;
    e.bus_byte = b;
    e.read_ack = ack;
    e.last     = 1'b0;
    op_run.push_back(e);
  endfunction

  // read part if any, then the stop; back to waiting for a start byte
  function automatic void close_frame();
    if (fr_reads != 0) begin
      push_op(OP_START_READ, {fr_addr, 1'b1}, 1'b0);
      for (int i = 0; i < fr_reads; i++)
        push_op(OP_READ, 8'h00, (i + 1 != fr_reads));
    end
    push_op(OP_STOP, 8'h00, 1'b0);
    fr_phase = FR_WAIT_START;
    fr_sends = '0;
    fr_reads = '0;
  endfunction

  function automatic void translate_byte(input logic [7:0] b);
    op_run.delete();
    case (fr_phase)
      FR_WAIT_START: begin
        if (b == START_BYTE)
          fr_phase = FR_ADDR;
      end
      FR_ADDR: begin
        fr_addr  = b[6:0];
        fr_phase = FR_SENDS;
      end
      FR_SENDS: begin
        fr_sends = b;
        fr_phase = FR_RECVS;
      end
      FR_RECVS: begin
        fr_reads = (b > MAX_RECV) ? MAX_RECV[5:0] : b[5:0];
        push_op(OP_START_WRITE, {fr_addr, 1'b0}, 1'b0);
        if (fr_sends == 0)
          close_frame();
        else
          fr_phase = FR_DATA;
      end
      FR_DATA: begin
        push_op(OP_WRITE, b, 1'b0);
        fr_sends = fr_sends - 8'd1;
        if (fr_sends == 0)
          close_frame();
      end
      default: fr_phase = FR_WAIT_START;
    endcase
    if (op_run.size() > 0)
      op_run[op_run.size() - 1].last = 1'b1;
    foreach (op_run[i])
      expected_ops.push_back(op_run[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    logic       v;
    logic [7:0] d;
    v = s_axis_tvalid;
    d = s_axis_tdata;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (s_fire)
        v = 1'b0;
      if (!v && !send_hold && serial_bytes.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        v = 1'b1;
        d = serial_bytes.pop_front();
      end
    end
    s_axis_tvalid <= v;
    s_axis_tdata  <= d;
  end

  always @(negedge clk) begin
    m_axis_tready <= !recv_holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (long_hold_go);
    recv_holding = 1'b1;
    repeat (400) @(posedge clk);
    recv_holding = 1'b0;
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    bus_op_t e;
    if (rst) begin
      s_fire <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_ops.size() == 0) begin
          $error("unexpected bus op %0d byte %02h", m_axis_tuser[2:0], m_axis_tdata);
          errors++;
        end else begin
          e = expected_ops.pop_front();
          ops_checked++;
          if (m_axis_tuser[2:0] !== e.op) begin
            $error("bus_op: expected %0d, got %0d", e.op, m_axis_tuser[2:0]);
            errors++;
          end
          if (m_axis_tdata !== e.bus_byte) begin
            $error("bus_byte: expected %02h, got %02h", e.bus_byte, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[3] !== e.read_ack) begin
            $error("read_ack: expected %0b, got %0b", e.read_ack, m_axis_tuser[3]);
            errors++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last_of_run: expected %0b, got %0b", e.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        translate_byte(s_axis_tdata);
        bytes_taken++;
      end
      s_fire <= s_axis_tvalid && s_axis_tready;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] sends,
                             input logic [7:0] recvs);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(addr);
    serial_bytes.push_back(sends);
    serial_bytes.push_back(recvs);
    for (int i = 0; i < sends; i++)
      serial_bytes.push_back(8'($urandom_range(255)));
    frames_queued++;
  endtask

  task automatic wait_drained();
    while (serial_bytes.size() > 0 || s_axis_tvalid || expected_ops.size() > 0)
      @(posedge clk);
  endtask

  // mostly well-formed frames, some noise and some frames cut after the address
  task automatic queue_random(input int n_items);
    int         start_len;
    int         r;
    logic [7:0] sends;
    logic [7:0] recvs;
    start_len = random_items;
    while (random_items - start_len < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        serial_bytes.push_back(8'($urandom_range(1, 255)));
        random_items++;
      end else if (r < 15) begin
        serial_bytes.push_back(START_BYTE);
        serial_bytes.push_back(8'($urandom_range(255)));
        random_items += 2;
      end else begin
        r = $urandom_range(99);
        sends = (r < 15) ? 8'd0 : (r < 90) ? 8'($urandom_range(1, 4))
                                           : 8'($urandom_range(5, 12));
        r = $urandom_range(99);
        recvs = (r < 20) ? 8'd0 : (r < 80) ? 8'($urandom_range(1, 8))
              : (r < 95) ? 8'($urandom_range(9, 32)) : 8'($urandom_range(33, 255));
        queue_frame(8'($urandom_range(255)), sends, recvs);
        random_items += 4 + sends;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty frame with wide address, noise while idle, saturated reads,
    // single read, start byte as data, zero sends with full reads
    serial_bytes.push_back(8'hFF);
    serial_bytes.push_back(8'h01);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(8'hFF);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(8'h80);
    serial_bytes.push_back(8'h01);
    serial_bytes.push_back(8'hFF);
    serial_bytes.push_back(8'hFF);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'h01);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(8'h55);
    serial_bytes.push_back(8'h02);
    serial_bytes.push_back(8'd33);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'hAA);
    serial_bytes.push_back(START_BYTE);
    serial_bytes.push_back(8'h2A);
    serial_bytes.push_back(8'h00);
    serial_bytes.push_back(8'd32);
    frames_queued += 5;
    wait_drained();

    // no idling, with a long receiver hold-off to back the block up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_go   = 1'b1;
    queue_frame(8'h7F, 8'd3, 8'd32);
    queue_frame(8'h12, 8'd1, 8'd32);
    queue_random(28);
    wait_drained();

    send_idle_pct  = 57;
    recv_stall_pct = 0;
    queue_random(28);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 57;
    queue_random(14);
    // sender pauses mid-phase until every expected op has come
    while (serial_bytes.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    send_hold = 1'b1;
    while (expected_ops.size() > 0)
      @(posedge clk);
    send_hold = 1'b0;
    queue_random(14);
    wait_drained();

    send_idle_pct  = 31;
    recv_stall_pct = 31;
    queue_random(28);
    wait_drained();

    repeat (50) @(posedge clk);
    $display("summary: %0d serial bytes taken, %0d frames queued, %0d bus ops checked",
             bytes_taken, frames_queued, ops_checked);
    $display("idling phases: none, sender 57%%, receiver 57%%, both 31%%, plus long hold-off");
    if (errors == 0 && expected_ops.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_ops.size() > 0)
        $error("%0d bus ops never arrived", expected_ops.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d bus ops outstanding", expected_ops.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
